// File: sv/bsxf_pkg.sv
// shared types and constants for the byte stuffing xor framer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bsxf_pkg;

   localparam int BYTE_W = 8;

   // configuration register indexes
   localparam logic [1:0] REG_START_FLAG  = 2'd0;
   localparam logic [1:0] REG_END_FLAG    = 2'd1;
   localparam logic [1:0] REG_ESCAPE_CODE = 2'd2;

   localparam logic [BYTE_W-1:0] START_FLAG_RESET  = 8'h7E;
   localparam logic [BYTE_W-1:0] END_FLAG_RESET    = 8'hAC;
   localparam logic [BYTE_W-1:0] ESCAPE_CODE_RESET = 8'h1B;

   // output slots of one item, in emission order
   localparam int NUM_SLOTS = 5;
   localparam int SLOT_START  = 0;
   localparam int SLOT_ESCAPE = 1;
   localparam int SLOT_DATA   = 2;
   localparam int SLOT_CHECK  = 3;
   localparam int SLOT_END    = 4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [BYTE_W-1:0] byte_type;

   // one classified item, everything the back end needs to emit it
   typedef struct packed {
      logic     has_start;
      byte_type start_byte;
      logic     escaped;
      byte_type escape_byte;
      byte_type data_byte;
      logic     has_tail;
      byte_type check_byte;
      byte_type end_byte;
   } entry_type;

   typedef struct packed {
      byte_type start_flag;
      byte_type end_flag;
      byte_type escape_code;
   } cfg_type;

endpackage

`default_nettype wire

// File: sv/byte_stuffing_xor_framer_unit.sv
// top level of the byte stuffing framer with xor checksum
// depends on bsxf_pkg, bsxf_front, bsxf_queue, bsxf_back
// the first output byte of an item passes through a queue slot and then the output register
// throughput: one output byte per cycle from the back end serializer while rsp_stall is low;
//   an item yields one to five bytes (start flag, escape prefix, byte, checksum, end flag)
// the front end takes an item whenever the two-entry queue has room
// reset: synchronous, clears frame state, queue and output valid; codes go to 7e, ac, 1b
`timescale 1ns / 1ps
`default_nettype none

module byte_stuffing_xor_framer_unit (
   input  wire         clock,
   input  wire         reset,
   // input channel
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_stuff_enable,
   input  wire         req_last_in_frame,
   // result channel
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_item,
   output logic        rsp_frame_done,
   // configuration port
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [3:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bsxf_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      cfg_write;
   logic [1:0] reg_index;

   entry_type front_entry;
   entry_type head;
   logic      push;
   logic      pop;
   logic      queue_full;
   logic      queue_not_empty;

   // register index from the word address
   assign reg_index = paddr[3:2];
   assign pready    = 1'b1;
   // write completes on the access cycle
   assign cfg_write = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_index)
            REG_START_FLAG:  cfg_in.start_flag  = pwdata[7:0];
            REG_END_FLAG:    cfg_in.end_flag    = pwdata[7:0];
            REG_ESCAPE_CODE: cfg_in.escape_code = pwdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // read back, unused index reads zero
   always_comb begin
      case (reg_index)
         REG_START_FLAG:  prdata = {24'd0, cfg_ff.start_flag};
         REG_END_FLAG:    prdata = {24'd0, cfg_ff.end_flag};
         REG_ESCAPE_CODE: prdata = {24'd0, cfg_ff.escape_code};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_flag  <= START_FLAG_RESET;
         cfg_ff.end_flag    <= END_FLAG_RESET;
         cfg_ff.escape_code <= ESCAPE_CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end classifies each transfer and tracks the open frame and checksum
   bsxf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_stuff_enable  (req_stuff_enable),
      .req_last_in_frame (req_last_in_frame),
      .cfg               (cfg_ff),
      .queue_full        (queue_full),
      .push              (push),
      .entry             (front_entry)
   );

   // decouples acceptance from serialization
   bsxf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   // back end emits the slots of the head item through the output register
   bsxf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (queue_not_empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_frame_done   (rsp_frame_done)
   );

endmodule

`default_nettype wire

// File: sv/bsxf_front.sv
// front end: accepts input transfers, classifies bytes, keeps frame state
// depends on bsxf_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsxf_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [7:0]          req_data_byte,
   input  wire                 req_stuff_enable,
   input  wire                 req_last_in_frame,
   input  bsxf_pkg::cfg_type   cfg,
   input  wire                 queue_full,
   output logic                push,
   output bsxf_pkg::entry_type entry
);
   import bsxf_pkg::*;

   logic     inside_frame_ff, inside_frame_in;
   byte_type running_xor_ff, running_xor_in;
   logic     special;
   byte_type masked;
   byte_type base_xor;
   byte_type new_xor;

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

   always_comb begin
      special = req_stuff_enable & ((req_data_byte == cfg.start_flag) |
                                    (req_data_byte == cfg.end_flag) |
                                    (req_data_byte == cfg.escape_code));
      masked   = req_data_byte ^ cfg.escape_code;
      base_xor = inside_frame_ff ? running_xor_ff : '0;
      new_xor  = special ? (base_xor ^ cfg.escape_code ^ masked) : (base_xor ^ req_data_byte);

      entry.has_start   = ~inside_frame_ff;
      entry.start_byte  = cfg.start_flag;
      entry.escaped     = special;
      entry.escape_byte = cfg.escape_code;
      entry.data_byte   = special ? masked : req_data_byte;
      entry.has_tail    = req_last_in_frame;
      entry.check_byte  = new_xor;
      entry.end_byte    = cfg.end_flag;

      inside_frame_in = inside_frame_ff;
      running_xor_in  = running_xor_ff;
      if (push) begin
         inside_frame_in = ~req_last_in_frame;
         running_xor_in  = req_last_in_frame ? '0 : new_xor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_frame_ff <= 1'b0;
         running_xor_ff  <= '0;
      end else begin
         inside_frame_ff <= inside_frame_in;
         running_xor_ff  <= running_xor_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/bsxf_queue.sv
// short queue of classified items between front and back end
// depends on bsxf_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsxf_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  bsxf_pkg::entry_type push_entry,
   input  wire                 pop,
   output logic                full,
   output logic                not_empty,
   output bsxf_pkg::entry_type head
);
   import bsxf_pkg::*;

   entry_type                slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_pop;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: sv/bsxf_back.sv
// back end: walks the slots of the head item, one output byte per cycle while rsp_stall is low
// depends on bsxf_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsxf_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 head_valid,
   input  bsxf_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_of_item,
   output logic                rsp_frame_done
);
   import bsxf_pkg::*;

   logic [NUM_SLOTS-1:0] sent_ff, sent_in;
   logic [NUM_SLOTS-1:0] present;
   logic [NUM_SLOTS-1:0] avail;
   logic [NUM_SLOTS-1:0] sel;
   logic [NUM_SLOTS-1:0] rest;
   logic                 advance;
   logic                 emit;
   byte_type             sel_byte;

   logic     rsp_valid_ff, rsp_valid_in;
   byte_type out_byte_ff;
   logic     last_ff;
   logic     done_ff;

   always_comb begin
      present              = '0;
      present[SLOT_START]  = head.has_start;
      present[SLOT_ESCAPE] = head.escaped;
      present[SLOT_DATA]   = 1'b1;
      present[SLOT_CHECK]  = head.has_tail;
      present[SLOT_END]    = head.has_tail;
      avail = present & ~sent_ff;
      // lowest pending slot
      sel   = avail & (~avail + 1'b1);
      rest  = avail & ~sel;

      case (1'b1)
         sel[SLOT_START]:  sel_byte = head.start_byte;
         sel[SLOT_ESCAPE]: sel_byte = head.escape_byte;
         sel[SLOT_CHECK]:  sel_byte = head.check_byte;
         sel[SLOT_END]:    sel_byte = head.end_byte;
         default:          sel_byte = head.data_byte;
      endcase

      advance = ~rsp_valid_ff | ~rsp_stall;
      emit    = advance & head_valid;
      pop     = emit & (rest == '0);

      rsp_valid_in = advance ? head_valid : rsp_valid_ff;
      sent_in      = sent_ff;
      if (emit) begin
         sent_in = (rest == '0) ? '0 : (sent_ff | sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sent_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sent_ff      <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff <= sel_byte;
         last_ff     <= (rest == '0);
         done_ff     <= sel[SLOT_END];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_last_of_item = last_ff;
   assign rsp_frame_done   = done_ff;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// self-checking testbench for byte_stuffing_xor_framer_unit
// depends on bsxf_pkg and the framer rtl, nothing else
`timescale 1ns / 1ps

module tb_top;
   import bsxf_pkg::*;

   localparam int         RANDOM_PER_PHASE = 38;
   localparam int         NUM_PHASES       = 6;
   localparam int         WATCHDOG_LIMIT   = 1000;
   localparam int         DRAIN_CYCLES     = 10;
   // index past the last register, writes there must be ignored
   localparam logic [1:0] REG_UNUSED       = 2'd3;

   typedef struct packed {
      byte_type out_byte;
      logic     last_of_item;
      logic     frame_done;
   } framed_byte_type;

   // keeps its own copy of the codes and frame state, predicts the framed stream
   class framer_scoreboard;
      byte_type        start_flag;
      byte_type        end_flag;
      byte_type        escape_code;
      bit              in_frame;
      byte_type        frame_xor;
      framed_byte_type bytes_due[$];
      int              errors;

      function new();
         start_flag  = START_FLAG_RESET;
         end_flag    = END_FLAG_RESET;
         escape_code = ESCAPE_CODE_RESET;
         in_frame    = 0;
         frame_xor   = '0;
         errors      = 0;
      endfunction

      function void set_code(logic [1:0] idx, byte_type value);
         case (idx)
            REG_START_FLAG:  start_flag  = value;
            REG_END_FLAG:    end_flag    = value;
            REG_ESCAPE_CODE: escape_code = value;
            default: ;
         endcase
      endfunction

      // one accepted input transfer -> the framed bytes it produces
      function void add_input_byte(byte_type data, bit stuff, bit last);
         byte_type        seq[$];
         byte_type        masked;
         framed_byte_type fb;
         if (!in_frame) begin
            seq.push_back(start_flag);
            in_frame  = 1;
            frame_xor = '0;
         end
         if (stuff && (data == start_flag || data == end_flag || data == escape_code)) begin
            masked = data ^ escape_code;
            seq.push_back(escape_code);
            seq.push_back(masked);
            frame_xor = frame_xor ^ escape_code ^ masked;
         end else begin
            seq.push_back(data);
            frame_xor = frame_xor ^ data;
         end
         if (last) begin
            seq.push_back(frame_xor);
            seq.push_back(end_flag);
            in_frame  = 0;
            frame_xor = '0;
         end
         foreach (seq[k]) begin
            fb.out_byte     = seq[k];
            fb.last_of_item = (k == seq.size() - 1);
            fb.frame_done   = last && (k == seq.size() - 1);
            bytes_due.push_back(fb);
         end
      endfunction

      function void check_output_byte(byte_type out_byte, logic last_of_item,
                                      logic frame_done);
         framed_byte_type fb;
         if (bytes_due.size() == 0) begin
            $error("unexpected output byte %h with nothing pending", out_byte);
            errors++;
            return;
         end
         fb = bytes_due.pop_front();
         if (out_byte !== fb.out_byte) begin
            $error("out_byte: expected %h, got %h", fb.out_byte, out_byte);
            errors++;
         end
         if (last_of_item !== fb.last_of_item) begin
            $error("last_of_item: expected %b, got %b", fb.last_of_item, last_of_item);
            errors++;
         end
         if (frame_done !== fb.frame_done) begin
            $error("frame_done: expected %b, got %b", fb.frame_done, frame_done);
            errors++;
         end
      endfunction

      function int pending();
         return bytes_due.size();
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // input channel
   logic       req_valid         = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte     = '0;
   logic       req_stuff_enable  = 1'b0;
   logic       req_last_in_frame = 1'b0;

   // result channel
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_item;
   logic       rsp_frame_done;

   // configuration port
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [3:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic [31:0] prdata;
   logic        pready;

   // per-phase idling modes: calm means no gaps on that side
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   framer_scoreboard sb = new();

   byte_stuffing_xor_framer_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_stuff_enable  (req_stuff_enable),
      .req_last_in_frame (req_last_in_frame),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_frame_done    (rsp_frame_done),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   wire req_xfer = req_valid && !req_stall;
   wire rsp_xfer = rsp_valid && !rsp_stall;
   wire csr_xfer = psel && penable && pwrite && pready;

   // monitors see pre-edge values, so ordering within the step does not matter
   always @(posedge clock) begin
      if (!reset && req_xfer) begin
         sb.add_input_byte(req_data_byte, req_stuff_enable, req_last_in_frame);
      end
      if (!reset && rsp_xfer) begin
         sb.check_output_byte(rsp_out_byte, rsp_last_of_item, rsp_frame_done);
      end
   end

   // watchdog: cycles without any transfer on any port
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || req_xfer || rsp_xfer || csr_xfer) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side: random stall before each transfer, then hold stall low until it goes
   initial begin
      int wait_cycles;
      wait (!reset);
      forever begin
         wait_cycles = rsp_calm ? 0 : $urandom_range(0, 15);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // apb write: setup cycle then access cycle, keeps the scoreboard codes in step
   task automatic write_code(logic [1:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_code(idx, value[7:0]);
      // bus returns to idle between writes
      @(posedge clock);
   endtask

   task automatic write_all_codes(byte_type start_v, byte_type end_v, byte_type esc_v);
      write_code(REG_START_FLAG, ({$urandom} & 32'hFFFF_FF00) | {24'd0, start_v});
      write_code(REG_END_FLAG, {24'd0, end_v});
      write_code(REG_ESCAPE_CODE, {24'd0, esc_v});
   endtask

   // one input transfer, with an optional gap in front; valid stays high afterwards
   task automatic send_byte(byte_type data, bit stuff, bit last);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_stuff_enable  <= stuff;
      req_last_in_frame <= last;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // random content, heavy on the current codes so stuffing is hit often
   task automatic send_random_byte();
      byte_type data;
      case ($urandom_range(0, 9))
         0, 1: data = sb.start_flag;
         2, 3: data = sb.end_flag;
         4, 5: data = sb.escape_code;
         default: data = 8'($urandom_range(0, 255));
      endcase
      send_byte(data, $urandom_range(0, 3) != 0, $urandom_range(0, 5) == 0);
   endtask

   // stop offering input and wait for every predicted byte to come out
   task automatic drain();
      req_valid <= 1'b0;
      // let the monitor record the last input transfer first
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with reset codes 7e / ac / 1b
      send_byte(8'h00, 1, 0);
      send_byte(8'hFF, 1, 0);
      send_byte(8'h7E, 1, 0);   // each code escaped when stuffing is on
      send_byte(8'hAC, 1, 0);
      send_byte(8'h1B, 1, 0);
      send_byte(8'h7E, 0, 0);   // code bytes pass raw when stuffing is off
      send_byte(8'hAC, 0, 0);
      send_byte(8'h1B, 0, 1);
      send_byte(8'h7E, 1, 1);   // single escaped byte frame: all five outputs
      send_byte(8'h7E, 0, 1);   // checksum equals the start flag, goes out raw
      send_byte(8'h55, 1, 0);
      send_byte(8'hF9, 1, 1);   // checksum equals the end flag
      send_byte(8'h80, 0, 0);
      send_byte(8'h01, 1, 0);
      send_byte(8'h7F, 1, 1);
      send_byte(8'hAA, 1, 0);   // frame left open into the first random phase
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // codes change only while idle; an open frame must survive the write
         case (phase)
            0: ;
            1: write_all_codes(8'h00, 8'hFF, 8'h00);  // zero escape, start equals escape
            2: write_all_codes(8'hFF, 8'h00, 8'hFF);
            3: begin
               write_all_codes(8'h7E, 8'h7E, 8'h7E);  // all codes equal
               write_code(REG_UNUSED, 32'h0000_0055); // no register there
            end
            4: write_all_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
            default: write_all_codes(START_FLAG_RESET, END_FLAG_RESET, ESCAPE_CODE_RESET);
         endcase
         req_calm = (phase % 3 == 1);
         rsp_calm = (phase % 2 == 1);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_random_byte();
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
